FILE: sv/stbep_pkg.sv
// package for the sorted table block entry parser
// holds the shared constants, codes and structs; no dependencies
package stbep_pkg;

  // block geometry
  localparam int unsigned MAX_BLOCK_BYTES = 65536;
  localparam int unsigned HEADER_BYTES    = 9;
  localparam int unsigned SIZE_WORD_BYTES = 4;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NEED_W  = WORD_W + 1;
  localparam int unsigned POS_W   = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned HC_W    = $clog2(HEADER_BYTES);
  localparam int unsigned LANE_W  = $clog2(SIZE_WORD_BYTES);

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TOMB_MASK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 8'd1;
  localparam logic [BYTE_W-1:0]    TOMB_MASK_RESET = 8'h01;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_ERROR  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    KIND_ENTRY   = 3'd0,
    KIND_END     = 3'd1,
    KIND_TRUNC   = 3'd2,
    KIND_OVERRUN = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [SIZE_W-1:0] block_size;
    logic              end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tombstone_mask;
    logic              big_endian_sizes;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [FIELD_W-1:0] key_offset;
    logic [FIELD_W-1:0] key_length;
    logic [FIELD_W-1:0] value_offset;
    logic [FIELD_W-1:0] value_length;
    logic               is_tombstone;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t r0;
    result_t r1;
  } res_push_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room;
  } fifo_status_t;

endpackage

FILE: sv/stbep_intf.sv
// channel interfaces of the sorted table block entry parser
// depends on stbep_pkg for widths
interface stbep_in_if;
  logic                              valid;
  logic                              ready;
  logic [stbep_pkg::BYTE_W-1:0]      data_byte;
  logic [stbep_pkg::SIZE_W-1:0]      block_size;
  logic                              end_of_block;

  modport source (output valid, output data_byte, output block_size,
                  output end_of_block, input ready);
  modport sink   (input valid, input data_byte, input block_size,
                  input end_of_block, output ready);
endinterface

interface stbep_out_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        kind;
  logic [stbep_pkg::FIELD_W-1:0]     key_offset;
  logic [stbep_pkg::FIELD_W-1:0]     key_length;
  logic [stbep_pkg::FIELD_W-1:0]     value_offset;
  logic [stbep_pkg::FIELD_W-1:0]     value_length;
  logic                              is_tombstone;
  logic                              last_result;

  modport source (output valid, output kind, output key_offset, output key_length,
                  output value_offset, output value_length, output is_tombstone,
                  output last_result, input ready);
  modport sink   (input valid, input kind, input key_offset, input key_length,
                  input value_offset, input value_length, input is_tombstone,
                  input last_result, output ready);
endinterface

interface stbep_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [stbep_pkg::CFG_IDX_W-1:0]   index;
  logic [stbep_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/stbep_cfg_regs.sv
// configuration registers: tombstone mask and size byte order
// depends on stbep_pkg and stbep_cfg_if
module stbep_cfg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  stbep_cfg_if.sink             cfg_i,
  output stbep_pkg::cfg_t       cfg_o
);

  logic [stbep_pkg::BYTE_W-1:0] tomb_mask_q;
  logic                         big_endian_q;

  // the port never stalls
  assign cfg_i.ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tomb_mask_q  <= stbep_pkg::TOMB_MASK_RESET;
      big_endian_q <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == stbep_pkg::CFG_TOMB_MASK) begin
        tomb_mask_q <= cfg_i.data[stbep_pkg::BYTE_W-1:0];
      end else if (cfg_i.index == stbep_pkg::CFG_BIG_ENDIAN) begin
        big_endian_q <= cfg_i.data[0];
      end
    end
  end

  assign cfg_o.tombstone_mask   = tomb_mask_q;
  assign cfg_o.big_endian_sizes = big_endian_q;

endmodule

FILE: sv/stbep_parse_core.sv
// entry parser: header assembly, body countdown and result building
// depends on stbep_pkg; feeds stbep_result_fifo
module stbep_parse_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  stbep_pkg::in_item_t     item_i,
  input  stbep_pkg::cfg_t         cfg_i,
  output stbep_pkg::res_push_t    push_o
);

  localparam int unsigned POS_W    = stbep_pkg::POS_W;
  localparam int unsigned HC_W     = stbep_pkg::HC_W;
  localparam int unsigned WORD_W   = stbep_pkg::WORD_W;
  localparam int unsigned NEED_W   = stbep_pkg::NEED_W;
  localparam int unsigned FW       = stbep_pkg::FIELD_W;
  localparam int unsigned BW       = stbep_pkg::BYTE_W;
  localparam int unsigned LANE_W_C = stbep_pkg::LANE_W;

  stbep_pkg::phase_e   phase_q, phase_d;
  logic [HC_W-1:0]     hc_q, hc_d;
  logic [WORD_W-1:0]   key_q, key_d;
  logic [WORD_W-1:0]   value_q, value_d;
  logic [BW-1:0]       flag_q, flag_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    blif_q, blif_d;
  logic [FW-1:0]       eks_q, eks_d;

  logic [POS_W-1:0]    size_c;
  logic [POS_W-1:0]    left_pos;
  logic [POS_W-1:0]    left_at;
  logic [POS_W-1:0]    pos_inc;
  logic [POS_W-1:0]    blif_dec;
  logic [NEED_W-1:0]   need;
  logic [WORD_W-1:0]   key_base;
  logic [WORD_W-1:0]   value_base;
  logic [WORD_W-1:0]   lane_word;
  logic                trunc;
  logic                hdr_last;
  logic                overrun;
  logic                empty_key;
  logic                err_any;
  logic                body_done;
  logic                entry_emit;
  logic                end_emit;
  stbep_pkg::kind_e    err_kind;
  stbep_pkg::kind_e    end_kind;
  stbep_pkg::result_t  entry_res;
  stbep_pkg::result_t  err_res;
  stbep_pkg::result_t  end_res;

  // payload size limited to the largest block
  assign size_c = (NEED_W'(item_i.block_size) > NEED_W'(stbep_pkg::MAX_BLOCK_BYTES))
                  ? POS_W'(stbep_pkg::MAX_BLOCK_BYTES) : POS_W'(item_i.block_size);

  // bytes left before and after this byte
  assign left_pos = (size_c > pos_q) ? POS_W'(size_c - pos_q) : '0;
  assign left_at  = (left_pos != '0) ? POS_W'(left_pos - 1'b1) : '0;
  assign pos_inc  = (pos_q < POS_W'(stbep_pkg::MAX_BLOCK_BYTES)) ? POS_W'(pos_q + 1'b1) : pos_q;
  assign blif_dec = (blif_q != '0) ? POS_W'(blif_q - 1'b1) : '0;

  // header checks
  assign need      = NEED_W'(key_q) + NEED_W'(value_q);
  assign trunc     = (phase_q == stbep_pkg::PH_HEADER) && (hc_q == '0)
                     && (left_pos < POS_W'(stbep_pkg::HEADER_BYTES));
  assign hdr_last  = (phase_q == stbep_pkg::PH_HEADER) && !trunc
                     && (hc_q == HC_W'(stbep_pkg::HEADER_BYTES - 1));
  assign overrun   = need > NEED_W'(left_at);
  assign empty_key = (key_q == '0);
  assign err_any   = trunc || (hdr_last && (overrun || empty_key));
  assign body_done = (phase_q == stbep_pkg::PH_BODY) && (blif_dec == '0);
  assign lane_word = WORD_W'(item_i.data_byte) << {hc_q[LANE_W_C-1:0], 3'b000};

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      stbep_pkg::PH_HEADER: begin
        if (err_any) begin
          phase_d = stbep_pkg::PH_ERROR;
        end else if (hdr_last) begin
          phase_d = stbep_pkg::PH_BODY;
        end
      end
      stbep_pkg::PH_BODY: begin
        if (body_done) begin
          phase_d = stbep_pkg::PH_HEADER;
        end
      end
      stbep_pkg::PH_ERROR: begin
        phase_d = stbep_pkg::PH_ERROR;
      end
      default: begin
        phase_d = stbep_pkg::PH_HEADER;
      end
    endcase
    // block end rearms the parser
    if (item_i.end_of_block) begin
      phase_d = stbep_pkg::PH_HEADER;
    end
  end

  // header assembly and counters
  always_comb begin
    hc_d       = hc_q;
    key_d      = key_q;
    value_d    = value_q;
    flag_d     = flag_q;
    pos_d      = pos_q;
    blif_d     = blif_q;
    eks_d      = eks_q;
    key_base   = (hc_q == '0) ? '0 : key_q;
    value_base = (hc_q == '0) ? '0 : value_q;
    unique case (phase_q)
      stbep_pkg::PH_HEADER: begin
        if (!trunc) begin
          key_d   = key_base;
          value_d = value_base;
          if (hc_q < HC_W'(stbep_pkg::SIZE_WORD_BYTES)) begin
            key_d = cfg_i.big_endian_sizes ? {key_base[WORD_W-BW-1:0], item_i.data_byte}
                                           : (key_base | lane_word);
          end else if (hc_q < HC_W'(2 * stbep_pkg::SIZE_WORD_BYTES)) begin
            value_d = cfg_i.big_endian_sizes ? {value_base[WORD_W-BW-1:0], item_i.data_byte}
                                             : (value_base | lane_word);
          end else begin
            flag_d = item_i.data_byte;
          end
          if (hdr_last) begin
            hc_d = '0;
            if (!overrun && !empty_key) begin
              eks_d  = FW'(pos_q + 1'b1);
              blif_d = POS_W'(need);
            end
          end else begin
            hc_d = HC_W'(hc_q + 1'b1);
          end
        end
      end
      stbep_pkg::PH_BODY: begin
        blif_d = blif_dec;
      end
      default: begin
      end
    endcase
    // position stands still while a faulty block drains
    if (phase_q != stbep_pkg::PH_ERROR) begin
      pos_d = pos_inc;
    end
    if (item_i.end_of_block) begin
      hc_d   = '0;
      pos_d  = '0;
      blif_d = '0;
    end
  end

  // result building
  always_comb begin
    err_kind = stbep_pkg::KIND_TRUNC;
    if (!trunc) begin
      err_kind = overrun ? stbep_pkg::KIND_OVERRUN : stbep_pkg::KIND_EMPTY;
    end
    if (phase_q == stbep_pkg::PH_BODY) begin
      end_kind = body_done ? stbep_pkg::KIND_END : stbep_pkg::KIND_OVERRUN;
    end else begin
      end_kind = hdr_last ? stbep_pkg::KIND_OVERRUN : stbep_pkg::KIND_TRUNC;
    end
    entry_emit = body_done;
    end_emit   = item_i.end_of_block && !err_any && (phase_q != stbep_pkg::PH_ERROR);

    entry_res              = '0;
    entry_res.kind         = stbep_pkg::KIND_ENTRY;
    entry_res.key_offset   = eks_q;
    entry_res.key_length   = key_q[FW-1:0];
    entry_res.value_offset = FW'(eks_q + key_q[FW-1:0]);
    entry_res.value_length = value_q[FW-1:0];
    entry_res.is_tombstone = |(flag_q & cfg_i.tombstone_mask);
    entry_res.last_result  = !end_emit;

    err_res             = '0;
    err_res.kind        = err_kind;
    err_res.last_result = 1'b1;

    end_res             = '0;
    end_res.kind        = end_kind;
    end_res.last_result = 1'b1;

    push_o.push0 = accept_i && (entry_emit || err_any || end_emit);
    push_o.push1 = accept_i && entry_emit && end_emit;
    push_o.r0    = entry_emit ? entry_res : (err_any ? err_res : end_res);
    push_o.r1    = end_res;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stbep_pkg::PH_HEADER;
      hc_q    <= '0;
      key_q   <= '0;
      value_q <= '0;
      flag_q  <= '0;
      pos_q   <= '0;
      blif_q  <= '0;
      eks_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      key_q   <= key_d;
      value_q <= value_d;
      flag_q  <= flag_d;
      pos_q   <= pos_d;
      blif_q  <= blif_d;
      eks_q   <= eks_d;
    end
  end

endmodule

FILE: sv/stbep_result_fifo.sv
// result queue: takes up to two results a cycle, hands out one
// depends on stbep_pkg and stbep_out_if
module stbep_result_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stbep_pkg::res_push_t     push_i,
  stbep_out_if.source              out_o,
  output stbep_pkg::fifo_status_t  status_o
);

  localparam int unsigned PTR_W = stbep_pkg::PTR_W;
  localparam int unsigned CNT_W = stbep_pkg::CNT_W;

  stbep_pkg::result_t               mem_q [stbep_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]                 wr_q, wr_d;
  logic [PTR_W-1:0]                 rd_q, rd_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic                             pop;
  stbep_pkg::result_t               head;

  assign pop  = (cnt_q != '0) && out_o.ready;
  assign head = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = PTR_W'(wr_q + PTR_W'(push_i.push0) + PTR_W'(push_i.push1));
    rd_d  = PTR_W'(rd_q + PTR_W'(pop));
    cnt_d = CNT_W'(cnt_q + CNT_W'(push_i.push0) + CNT_W'(push_i.push1) - CNT_W'(pop));
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.push1) begin
      mem_q[PTR_W'(wr_q + 1'b1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // output channel
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.kind         = head.kind;
  assign out_o.key_offset   = head.key_offset;
  assign out_o.key_length   = head.key_length;
  assign out_o.value_offset = head.value_offset;
  assign out_o.value_length = head.value_length;
  assign out_o.is_tombstone = head.is_tombstone;
  assign out_o.last_result  = head.last_result;

  // room for the two results one byte can cause
  assign status_o.count = cnt_q;
  assign status_o.room  = (cnt_q <= CNT_W'(stbep_pkg::FIFO_DEPTH - 2));

endmodule

FILE: sv/sorted_table_block_entry_parser.sv
// top level of the sorted table block entry parser
// depends on stbep_pkg, stbep_intf, stbep_cfg_regs, stbep_parse_core, stbep_result_fifo
//
// Usage:
//   in_i carries one payload byte per transaction with the block's payload size
//   and an end_of_block flag on the final byte. out_o carries result
//   transactions: one per finished entry, one error per faulty block (the rest
//   of that block is dropped), and otherwise a block end result on the final byte.
//   cfg_i writes the tombstone mask (index 0) and the size byte order
//   (index 1); it never stalls and should be written between blocks.
// Throughput:
//   one byte is taken every cycle while in_i.ready is high; the parser state
//   updates as each byte is taken and its results enter the result queue. A byte
//   causes at most two results (an entry followed by the block end); they leave
//   one per cycle while out_o.ready is high, from a four deep result queue.
// Stall and reset:
//   in_i.ready drops while the queue has fewer than two free slots, so a
//   stalled receiver holds the input back without losing results.
//   Reset empties the queue, returns the parser to the header phase at
//   payload offset zero and sets the mask to 1 and the byte order to little.
module sorted_table_block_entry_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  stbep_in_if.sink    in_i,
  stbep_out_if.source out_o,
  stbep_cfg_if.sink   cfg_i
);

  stbep_pkg::cfg_t          cfg;
  stbep_pkg::in_item_t      item;
  stbep_pkg::res_push_t     push;
  stbep_pkg::fifo_status_t  fifo_st;
  logic                     accept;

  // input transaction
  assign in_i.ready        = fifo_st.room;
  assign accept            = in_i.valid && in_i.ready;
  assign item.data_byte    = in_i.data_byte;
  assign item.block_size   = in_i.block_size;
  assign item.end_of_block = in_i.end_of_block;

  stbep_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  stbep_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .push_o   (push)
  );

  stbep_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .out_o    (out_o),
    .status_o (fifo_st)
  );

`ifndef NO_ASSERTIONS
  // queue never holds more than its depth
  a_fifo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_st.count <= stbep_pkg::CNT_W'(stbep_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // a result that is not last always has its partner queued behind it
  a_pair_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_result) |-> (fifo_st.count >= 2))
    else $error("first result of a pair without its partner");

  // non-entry results carry zero entry fields
  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind != stbep_pkg::KIND_ENTRY)) |->
      ((out_o.key_offset == '0) && (out_o.key_length == '0) &&
       (out_o.value_offset == '0) && (out_o.value_length == '0) &&
       !out_o.is_tombstone))
    else $error("status result with entry fields set");

  // an entry result always has a key
  a_entry_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == stbep_pkg::KIND_ENTRY)) |-> (out_o.key_length != '0))
    else $error("entry result with empty key");
`endif

endmodule

FILE: dv/sorted_table_block_entry_parser_tb.sv
// self-checking testbench for the sorted table block entry parser
// streams directed and random block payloads, predicts every result in a local parser
// mirror and checks each result field; depends on stbep_pkg, stbep_intf and the rtl
module sorted_table_block_entry_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned SEGMENTS       = 6;
  localparam int unsigned SEGMENT_BYTES  = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stbep_in_if  in_ch ();
  stbep_out_if out_ch ();
  stbep_cfg_if cfg_ch ();

  sorted_table_block_entry_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // payload bytes waiting for the driver, and results the parser still owes
  stbep_pkg::in_item_t  payload_q [$];
  stbep_pkg::result_t   pending_results [$];
  logic [7:0]           block_bytes [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // mirror of the parser configuration and state
  logic [stbep_pkg::BYTE_W-1:0]  tomb_mask;
  logic                          size_msb_first;
  stbep_pkg::phase_e             parse_phase;
  logic [3:0]                    hdr_count;
  logic [stbep_pkg::WORD_W-1:0]  hdr_key_len;
  logic [stbep_pkg::WORD_W-1:0]  hdr_value_len;
  logic [stbep_pkg::BYTE_W-1:0]  flag_byte;
  int unsigned                   parse_pos;
  logic [stbep_pkg::WORD_W-1:0]  body_left;
  logic [stbep_pkg::FIELD_W-1:0] key_start;

  function automatic int unsigned room_left(input int unsigned size, input int unsigned at);
    return (size > at) ? size - at : 0;
  endfunction

  function automatic stbep_pkg::result_t make_result(input stbep_pkg::kind_e k,
      input logic [stbep_pkg::FIELD_W-1:0] koff, input logic [stbep_pkg::FIELD_W-1:0] klen,
      input logic [stbep_pkg::FIELD_W-1:0] voff, input logic [stbep_pkg::FIELD_W-1:0] vlen,
      input logic tomb);
    stbep_pkg::result_t r;
    r.kind         = k;
    r.key_offset   = koff;
    r.key_length   = klen;
    r.value_offset = voff;
    r.value_length = vlen;
    r.is_tombstone = tomb;
    r.last_result  = 1'b0;
    return r;
  endfunction

  function automatic void restart_block();
    parse_phase = stbep_pkg::PH_HEADER;
    hdr_count   = '0;
    parse_pos   = 0;
    body_left   = '0;
  endfunction

  // advance the parser mirror by one payload byte and queue what it emits
  function automatic void parse_payload_byte(input stbep_pkg::in_item_t it);
    int unsigned        size, cur, at, n;
    logic [63:0]        need;
    logic               err_hit;
    stbep_pkg::kind_e   err_kind, end_kind;
    stbep_pkg::result_t res [2];
    size     = (it.block_size > stbep_pkg::MAX_BLOCK_BYTES) ? stbep_pkg::MAX_BLOCK_BYTES
                                                             : it.block_size;
    cur      = parse_pos;
    n        = 0;
    err_hit  = 1'b0;
    err_kind = stbep_pkg::KIND_TRUNC;

    // dropping the rest of a faulty block
    if (parse_phase == stbep_pkg::PH_ERROR) begin
      if (it.end_of_block) restart_block();
      return;
    end

    if (parse_phase == stbep_pkg::PH_HEADER) begin
      if (hdr_count == 0 && room_left(size, cur) < stbep_pkg::HEADER_BYTES) begin
        err_hit  = 1'b1;
        err_kind = stbep_pkg::KIND_TRUNC;
      end else begin
        if (hdr_count == 0) begin
          hdr_key_len   = '0;
          hdr_value_len = '0;
        end
        // size words in either byte order, then the flag byte
        if (hdr_count < stbep_pkg::SIZE_WORD_BYTES) begin
          if (size_msb_first) hdr_key_len = {hdr_key_len[23:0], it.data_byte};
          else hdr_key_len = hdr_key_len | ({24'd0, it.data_byte} << (8 * hdr_count));
        end else if (hdr_count < 2 * stbep_pkg::SIZE_WORD_BYTES) begin
          if (size_msb_first) hdr_value_len = {hdr_value_len[23:0], it.data_byte};
          else hdr_value_len = hdr_value_len |
              ({24'd0, it.data_byte} << (8 * (hdr_count - stbep_pkg::SIZE_WORD_BYTES)));
        end else begin
          flag_byte = it.data_byte;
        end
        hdr_count = hdr_count + 4'd1;
        // full header: overrun check first, then empty key
        if (hdr_count >= stbep_pkg::HEADER_BYTES) begin
          at        = cur + 1;
          need      = {32'd0, hdr_key_len} + {32'd0, hdr_value_len};
          hdr_count = '0;
          if (need > 64'(room_left(size, at))) begin
            err_hit  = 1'b1;
            err_kind = stbep_pkg::KIND_OVERRUN;
          end else if (hdr_key_len == 0) begin
            err_hit  = 1'b1;
            err_kind = stbep_pkg::KIND_EMPTY;
          end else begin
            key_start   = 16'(at);
            body_left   = need[stbep_pkg::WORD_W-1:0];
            parse_phase = stbep_pkg::PH_BODY;
          end
        end
      end
    end else begin
      // key and value bytes
      if (body_left != 0) body_left = body_left - 1;
      if (body_left == 0) begin
        res[n] = make_result(stbep_pkg::KIND_ENTRY, key_start, hdr_key_len[15:0],
                             key_start + hdr_key_len[15:0], hdr_value_len[15:0],
                             |(flag_byte & tomb_mask));
        n++;
        parse_phase = stbep_pkg::PH_HEADER;
      end
    end

    if (err_hit) begin
      res[n] = make_result(err_kind, '0, '0, '0, '0, 1'b0);
      n++;
      parse_phase = stbep_pkg::PH_ERROR;
    end

    parse_pos = (cur < stbep_pkg::MAX_BLOCK_BYTES) ? cur + 1 : stbep_pkg::MAX_BLOCK_BYTES;

    // block end: clean finish only on a header boundary
    if (it.end_of_block) begin
      if (!err_hit) begin
        if (parse_phase == stbep_pkg::PH_HEADER && hdr_count == 0)
          end_kind = stbep_pkg::KIND_END;
        else if (parse_phase == stbep_pkg::PH_HEADER)
          end_kind = stbep_pkg::KIND_TRUNC;
        else
          end_kind = stbep_pkg::KIND_OVERRUN;
        res[n] = make_result(end_kind, '0, '0, '0, '0, 1'b0);
        n++;
      end
      restart_block();
    end

    if (n > 0) res[n-1].last_result = 1'b1;
    for (int unsigned i = 0; i < n; i++)
      pending_results.insert(pending_results.size(), res[i]);
  endfunction

  // stimulus construction
  function automatic void add_byte(input logic [7:0] b);
    block_bytes.insert(block_bytes.size(), b);
  endfunction

  function automatic void add_word(input logic [stbep_pkg::WORD_W-1:0] w);
    for (int i = 0; i < stbep_pkg::SIZE_WORD_BYTES; i++)
      add_byte(size_msb_first ? w[8*(stbep_pkg::SIZE_WORD_BYTES-1-i) +: 8] : w[8*i +: 8]);
  endfunction

  function automatic void add_entry(input logic [stbep_pkg::WORD_W-1:0] ksz,
                                    input logic [stbep_pkg::WORD_W-1:0] vsz,
                                    input logic [stbep_pkg::BYTE_W-1:0] flag,
                                    input int unsigned body);
    add_word(ksz);
    add_word(vsz);
    add_byte(flag);
    repeat (body) add_byte(8'($urandom));
  endfunction

  // hand the first count built bytes to the driver as one block
  function automatic int unsigned emit_block(input int unsigned size, input int unsigned count);
    stbep_pkg::in_item_t it;
    for (int unsigned i = 0; i < count; i++) begin
      it.data_byte    = block_bytes[i];
      it.block_size   = 17'(size);
      it.end_of_block = (i == count - 1);
      payload_q.insert(payload_q.size(), it);
    end
    block_bytes.delete();
    return count;
  endfunction

  // mostly well-formed chains, the rest broken or plain noise
  function automatic int unsigned queue_random_block();
    int unsigned style, full_len, keep, size;
    logic [stbep_pkg::WORD_W-1:0] klen, vlen;
    style = $urandom_range(99);
    if (style >= 92) begin
      repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
      full_len = block_bytes.size();
      size = ($urandom_range(3) == 0) ? $urandom_range(1, stbep_pkg::MAX_BLOCK_BYTES)
                                      : $urandom_range(1, 30);
      return emit_block(size, full_len);
    end
    repeat ($urandom_range(1, 3)) begin
      klen = $urandom_range(1, 6);
      vlen = $urandom_range(0, 6);
      if (style >= 65) begin
        case ($urandom_range(3))
          0: klen = '0;
          1: klen = $urandom();
          2: vlen = $urandom();
          default: ;
        endcase
      end
      add_entry(klen, vlen, 8'($urandom),
                (klen <= 6 && vlen <= 6) ? klen + vlen : $urandom_range(4));
    end
    full_len = block_bytes.size();
    keep     = full_len;
    if (style < 50) begin
      size = full_len;
    end else if (style < 65) begin
      size = $urandom_range(full_len, stbep_pkg::MAX_BLOCK_BYTES);
    end else begin
      if ($urandom_range(1)) keep = $urandom_range(1, full_len);
      case ($urandom_range(2))
        0: size = full_len;
        1: size = $urandom_range(1, full_len);
        default: size = $urandom_range(1, stbep_pkg::MAX_BLOCK_BYTES);
      endcase
    end
    return emit_block(size, keep);
  endfunction

  // register write, mirrored once the transaction completes
  task automatic write_register(input logic [stbep_pkg::CFG_IDX_W-1:0] idx,
                                input logic [stbep_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      stbep_pkg::CFG_TOMB_MASK:  tomb_mask = val;
      stbep_pkg::CFG_BIG_ENDIAN: size_msb_first = val[0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // wait until every byte is taken and every result is back
  task automatic settle();
    while (payload_q.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // byte driver
  always @(posedge clk_i) begin : drive_bytes
    stbep_pkg::in_item_t nxt;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) parse_payload_byte(payload_q.pop_front());
      if (!in_ch.valid || in_ch.ready) begin
        if (payload_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = payload_q[0];
          in_ch.valid        <= 1'b1;
          in_ch.data_byte    <= nxt.data_byte;
          in_ch.block_size   <= nxt.block_size;
          in_ch.end_of_block <= nxt.end_of_block;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result monitor with random back pressure
  always @(posedge clk_i) begin : watch_results
    stbep_pkg::result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction, kind %0d", out_ch.kind);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("key_offset", want.key_offset, out_ch.key_offset);
          check_field("key_length", want.key_length, out_ch.key_length);
          check_field("value_offset", want.value_offset, out_ch.value_offset);
          check_field("value_length", want.value_length, out_ch.value_length);
          check_field("is_tombstone", want.is_tombstone, out_ch.is_tombstone);
          check_field("last_result", want.last_result, out_ch.last_result);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_table_block_entry_parser: mismatch");
      $finish;
    end
  end

  initial begin : run_blocks
    int unsigned                  sent;
    logic [stbep_pkg::BYTE_W-1:0] mask_sel;
    logic                         msb_sel;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.block_size   = '0;
    in_ch.end_of_block = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    tomb_mask          = stbep_pkg::TOMB_MASK_RESET;
    size_msb_first     = 1'b0;
    hdr_key_len        = '0;
    hdr_value_len      = '0;
    flag_byte          = '0;
    key_start          = '0;
    restart_block();
    send_idle_pct      = 32;
    recv_stall_pct     = 73;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_register(stbep_pkg::CFG_TOMB_MASK, stbep_pkg::TOMB_MASK_RESET);
    write_register(stbep_pkg::CFG_BIG_ENDIAN, 8'd0);

    // directed: zero size, entry on the last byte, short block with
    // ignored tail, empty key at the largest size
    sent = 0;
    add_byte(8'hFF);
    sent += emit_block(0, 1);
    add_entry(32'd1, 32'd0, 8'hFF, 1);
    sent += emit_block(10, 10);
    add_byte(8'h00);
    add_byte(8'h00);
    sent += emit_block(5, 2);
    add_entry(32'd0, 32'd0, 8'h01, 0);
    sent += emit_block(stbep_pkg::MAX_BLOCK_BYTES, 9);

    // random segments under changing settings and idling
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      send_idle_pct  = (seg < 2) ? 32 : (seg < 4) ? 73 : 0;
      recv_stall_pct = (seg < 2) ? 73 : (seg < 4) ? 32 : 0;
      case (seg)
        0: begin mask_sel = 8'h00; msb_sel = 1'b1; end
        1: begin mask_sel = 8'hFF; msb_sel = 1'b0; end
        2: begin mask_sel = 8'($urandom); msb_sel = 1'b1; end
        3: begin mask_sel = 8'h80; msb_sel = 1'b0; end
        4: begin mask_sel = 8'($urandom); msb_sel = 1'($urandom); end
        default: begin mask_sel = 8'hFF; msb_sel = 1'b1; end
      endcase
      write_register(stbep_pkg::CFG_TOMB_MASK, mask_sel);
      write_register(stbep_pkg::CFG_BIG_ENDIAN, {7'd0, msb_sel});
      sent = 0;
      while (sent < SEGMENT_BYTES) sent += queue_random_block();
    end

    settle();
    if (fail_count == 0) begin
      $display("sorted_table_block_entry_parser: match");
    end else begin
      $display("sorted_table_block_entry_parser: mismatch");
    end
    $finish;
  end

endmodule
